// ===== hdl/ghd_pkg.sv =====
// ----------------------------------------------------------------------------
// ghd_pkg
// Shared types, sequencer codes and arithmetic constants for the GPS home
// distance block.
// ----------------------------------------------------------------------------
package ghd_pkg;

    // Sequencer steps; the controller state doubles as the datapath command.
    localparam int STATE_W = 5;
    localparam logic [STATE_W-1:0] ST_IDLE = 5'd0;
    localparam logic [STATE_W-1:0] ST_C1   = 5'd1;
    localparam logic [STATE_W-1:0] ST_C2   = 5'd2;
    localparam logic [STATE_W-1:0] ST_C3   = 5'd3;
    localparam logic [STATE_W-1:0] ST_C4   = 5'd4;
    localparam logic [STATE_W-1:0] ST_C5   = 5'd5;
    localparam logic [STATE_W-1:0] ST_C6   = 5'd6;
    localparam logic [STATE_W-1:0] ST_C7   = 5'd7;
    localparam logic [STATE_W-1:0] ST_K1   = 5'd8;
    localparam logic [STATE_W-1:0] ST_K2   = 5'd9;
    localparam logic [STATE_W-1:0] ST_K3   = 5'd10;
    localparam logic [STATE_W-1:0] ST_K4   = 5'd11;
    localparam logic [STATE_W-1:0] ST_K5   = 5'd12;
    localparam logic [STATE_W-1:0] ST_K6   = 5'd13;
    localparam logic [STATE_W-1:0] ST_K7   = 5'd14;
    localparam logic [STATE_W-1:0] ST_K8   = 5'd15;
    localparam logic [STATE_W-1:0] ST_K9   = 5'd16;
    localparam logic [STATE_W-1:0] ST_K10  = 5'd17;
    localparam logic [STATE_W-1:0] ST_K11  = 5'd18;
    localparam logic [STATE_W-1:0] ST_M1   = 5'd19;
    localparam logic [STATE_W-1:0] ST_M2   = 5'd20;
    localparam logic [STATE_W-1:0] ST_M3   = 5'd21;
    localparam logic [STATE_W-1:0] ST_M4   = 5'd22;
    localparam logic [STATE_W-1:0] ST_D1   = 5'd23;
    localparam logic [STATE_W-1:0] ST_D2   = 5'd24;
    localparam logic [STATE_W-1:0] ST_D3   = 5'd25;
    localparam logic [STATE_W-1:0] ST_S1   = 5'd26;
    localparam logic [STATE_W-1:0] ST_S2   = 5'd27;
    localparam logic [STATE_W-1:0] ST_S3   = 5'd28;
    localparam logic [STATE_W-1:0] ST_S4   = 5'd29;
    localparam logic [STATE_W-1:0] ST_SQRT = 5'd30;
    localparam logic [STATE_W-1:0] ST_FIN  = 5'd31;

    localparam logic OPC_CAPTURE = 1'b0;
    localparam logic OPC_MEASURE = 1'b1;

    localparam logic COORD_LAT = 1'b0;
    localparam logic COORD_LON = 1'b1;

    localparam int CNT_W      = 5;
    localparam int SQRT_STEPS = 27;

    // Reciprocal multipliers: floor(x / d) = (x * M) >> S over the used range.
    localparam logic [31:0] DIV100_M   = 32'd5243;
    localparam logic [31:0] DIV3_M     = 32'd11184811;
    localparam logic [31:0] DIV1E4_M   = 32'd109951163;
    localparam logic [31:0] DIV25_M    = 32'd687194768;
    localparam logic [31:0] DIV81_M    = 32'd3393554407;
    localparam logic [31:0] DIV12500_M = 32'd21990233;
    // floor(2^45 / 10^6): applied to x >> 13, gives x / 10^6 low by at most one
    localparam logic [31:0] DIV1E6_M   = 32'd35184372;

    localparam logic [31:0] K_100     = 32'd100;
    localparam logic [31:0] K_10000   = 32'd10000;
    localparam logic [31:0] K_5       = 32'd5;
    localparam logic [31:0] K_1E6     = 32'd1000000;
    localparam logic [31:0] K_123370  = 32'd123370;
    localparam logic [31:0] K_139     = 32'd139;
    localparam logic [24:0] K_1E7     = 25'd10000000;

    localparam logic [17:0] MPD_RESET = 18'd111194;
    localparam logic [29:0] LAT_CAP   = 30'd134217727;
    localparam logic [29:0] LON_CAP   = 30'd268435455;
    localparam logic [18:0] AXIS_CAP  = 19'd131071;
    localparam logic [53:0] DIST_CAP  = 54'd33554431;
    localparam logic [53:0] SQRT_B0   = 54'd4503599627370496;

    typedef struct packed {
        logic [STATE_W-1:0] op;
        logic               coord;
        logic               load;
    } t_cmd;

    typedef struct packed {
        logic opcode;
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/ghd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ghd_ctrl
// Sequencer: steps the datapath through conversion, home capture or
// distance measurement, the divide by one million and the square root.
// ----------------------------------------------------------------------------
module ghd_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  ghd_pkg::t_stat i_stat,
    output logic         o_ready,
    output ghd_pkg::t_cmd  o_cmd
);
    import ghd_pkg::*;

    logic [STATE_W-1:0] r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_coord, n_coord;
    logic               w_accept;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = o_ready && i_in_valid;

    assign o_cmd.op    = r_state;
    assign o_cmd.coord = r_coord;
    assign o_cmd.load  = w_accept;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_coord = r_coord;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_C1;
                    n_coord = COORD_LAT;
                end
            end
            ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6,
            ST_K1, ST_K2, ST_K3, ST_K4, ST_K5, ST_K6, ST_K7, ST_K8, ST_K9, ST_K10,
            ST_M1, ST_M2, ST_M3, ST_M4, ST_D1, ST_D2, ST_D3,
            ST_S1, ST_S2, ST_S3: begin
                n_state = r_state + 5'd1;
            end
            ST_C7: begin
                if (r_coord == COORD_LAT) begin
                    n_coord = COORD_LON;
                    n_state = ST_C1;
                end else if (i_stat.opcode == OPC_MEASURE) begin
                    n_state = ST_M1;
                end else begin
                    n_state = ST_K1;
                end
            end
            ST_K11: n_state = ST_FIN;
            ST_S4: begin
                n_state = ST_SQRT;
                n_cnt   = '0;
            end
            ST_SQRT: begin
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            ST_FIN: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_coord <= COORD_LAT;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_coord <= n_coord;
        end
    end

    a_accept_starts_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_C1) && (r_coord == COORD_LAT))
        else $error("accepted item did not start latitude conversion");

    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) && !i_stat.out_free |=> (r_state == ST_FIN))
        else $error("result left before the output register was free");

    a_sqrt_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT) |-> (r_cnt < CNT_W'(SQRT_STEPS)))
        else $error("square root counter overran");

endmodule

// ===== hdl/ghd_datapath.sv =====
// ----------------------------------------------------------------------------
// ghd_datapath
// Shared multiplier, coordinate conversion, home state, reciprocal divide by
// one million, bit-serial square root and output register.
// ----------------------------------------------------------------------------
module ghd_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ghd_pkg::t_cmd  i_cmd,
    output ghd_pkg::t_stat o_stat,
    input  logic           i_cfg_wr_en,
    input  logic [17:0]    i_cfg_wr_data,
    input  logic           i_opcode,
    input  logic [13:0]    i_lat_whole,
    input  logic [13:0]    i_lat_frac,
    input  logic [14:0]    i_lon_whole,
    input  logic [13:0]    i_lon_frac,
    input  logic [15:0]    i_baro_altitude,
    input  logic [15:0]    i_gps_altitude,
    input  logic           i_use_baro,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [24:0]    o_distance,
    output logic [24:0]    o_max_distance
);
    import ghd_pkg::*;

    // captured item
    logic        r_opcode;
    logic [13:0] r_lat_whole, r_lat_frac, r_lon_frac;
    logic [14:0] r_lon_whole;
    logic [15:0] r_alt;

    // configuration and home state
    logic [17:0] r_mpd;
    logic [26:0] r_home_lat;
    logic [27:0] r_home_lon;
    logic [16:0] r_axis;
    logic [24:0] r_peak;

    // working registers
    logic [63:0] r_prod;
    logic [8:0]  r_q;
    logic [20:0] r_f;
    logic [26:0] r_lat, r_dlat;
    logic [27:0] r_lon, r_dlon;
    logic [14:0] r_a2;
    logic [24:0] r_plus, r_s;
    logic [44:0] r_num_n, r_num_e;
    logic [25:0] r_qn, r_qe;
    logic [53:0] r_sum, r_res, r_bit;

    logic        r_out_valid;
    logic [24:0] r_out_dist, r_out_max;

    logic [31:0] w_mul_a, w_mul_b;
    logic        w_mul_en;
    logic [14:0] w_whole, w_diff;
    logic [13:0] w_frac;
    logic [19:0] w_t;
    logic [29:0] w_micro;
    logic [25:0] w_minus;
    logic [44:0] w_rem_n, w_rem_e;
    logic [53:0] w_trial;
    logic [24:0] w_dist;
    logic [15:0] w_alt_raw;
    logic        w_out_free;

    assign w_whole   = (i_cmd.coord == COORD_LON) ? r_lon_whole : {1'b0, r_lat_whole};
    assign w_frac    = (i_cmd.coord == COORD_LON) ? r_lon_frac : r_lat_frac;
    assign w_diff    = w_whole - r_prod[14:0];
    assign w_t       = r_prod[19:0] + {6'd0, w_frac};
    assign w_micro   = {1'b0, r_prod[28:0]} + {9'd0, r_f};
    assign w_minus   = r_prod[63:38];
    // remainder left by the estimated quotient; one more step when it reaches 10^6
    assign w_rem_n   = r_num_n - r_prod[44:0];
    assign w_rem_e   = r_num_e - r_prod[44:0];
    assign w_trial   = r_res + r_bit;
    assign w_dist    = (r_res > DIST_CAP) ? DIST_CAP[24:0] : r_res[24:0];
    assign w_alt_raw = i_use_baro ? i_baro_altitude : i_gps_altitude;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_stat.opcode   = r_opcode;
    assign o_stat.out_free = w_out_free;

    // multiplier operand select
    always_comb begin
        w_mul_en = 1'b1;
        w_mul_a  = '0;
        w_mul_b  = '0;
        case (i_cmd.op)
            ST_C1: begin w_mul_a = {17'd0, w_whole};           w_mul_b = DIV100_M;   end
            ST_C2: begin w_mul_a = {23'd0, r_prod[27:19]};     w_mul_b = K_100;      end
            ST_C3: begin w_mul_a = {25'd0, w_diff[6:0]};       w_mul_b = K_10000;    end
            ST_C4: begin w_mul_a = {12'd0, w_t};               w_mul_b = K_5;        end
            ST_C5: begin w_mul_a = {9'd0, r_prod[22:0]};       w_mul_b = DIV3_M;     end
            ST_C6: begin w_mul_a = {23'd0, r_q};               w_mul_b = K_1E6;      end
            ST_K1: begin w_mul_a = {5'd0, r_lat};              w_mul_b = DIV1E4_M;   end
            ST_K2: begin w_mul_a = {18'd0, r_prod[53:40]};
                         w_mul_b = {18'd0, r_prod[53:40]};                           end
            ST_K3: begin w_mul_a = {4'd0, r_prod[27:0]};       w_mul_b = DIV1E4_M;   end
            ST_K4: begin w_mul_a = {17'd0, r_prod[54:40]};
                         w_mul_b = {17'd0, r_prod[54:40]};                           end
            ST_K5: begin w_mul_a = {3'd0, r_prod[28:0]};       w_mul_b = DIV25_M;    end
            ST_K6: begin w_mul_a = {17'd0, r_a2};              w_mul_b = K_123370;   end
            ST_K7: begin w_mul_a = r_prod[31:0];               w_mul_b = DIV81_M;    end
            ST_K9: begin w_mul_a = {7'd0, r_s};                w_mul_b = DIV12500_M; end
            ST_K10: begin w_mul_a = {21'd0, r_prod[48:38]};    w_mul_b = K_139;      end
            ST_M2: begin w_mul_a = {14'd0, r_mpd};             w_mul_b = {5'd0, r_dlat}; end
            ST_M3: begin w_mul_a = {15'd0, r_axis};            w_mul_b = {4'd0, r_dlon}; end
            ST_M4: begin w_mul_a = r_num_n[44:13];             w_mul_b = DIV1E6_M;   end
            ST_D1: begin w_mul_a = r_num_e[44:13];             w_mul_b = DIV1E6_M;   end
            ST_D2: begin w_mul_a = {6'd0, r_qn};               w_mul_b = K_1E6;      end
            ST_D3: begin w_mul_a = {6'd0, r_qe};               w_mul_b = K_1E6;      end
            ST_S1: begin w_mul_a = {6'd0, r_qn};               w_mul_b = {6'd0, r_qn};   end
            ST_S2: begin w_mul_a = {6'd0, r_qe};               w_mul_b = {6'd0, r_qe};   end
            ST_S3: begin w_mul_a = {16'd0, r_alt};             w_mul_b = {16'd0, r_alt}; end
            default: w_mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        if (i_cmd.load) begin
            r_opcode    <= i_opcode;
            r_lat_whole <= i_lat_whole;
            r_lat_frac  <= i_lat_frac;
            r_lon_whole <= i_lon_whole;
            r_lon_frac  <= i_lon_frac;
            r_alt       <= w_alt_raw[15] ? (~w_alt_raw + 16'd1) : w_alt_raw;
        end
        case (i_cmd.op)
            ST_C2: r_q <= r_prod[27:19];
            ST_C6: r_f <= r_prod[45:25];
            ST_C7: begin
                if (i_cmd.coord == COORD_LAT) begin
                    r_lat <= (w_micro > LAT_CAP) ? LAT_CAP[26:0] : w_micro[26:0];
                end else begin
                    r_lon <= (w_micro > LON_CAP) ? LON_CAP[27:0] : w_micro[27:0];
                end
            end
            ST_K4: r_a2   <= r_prod[54:40];
            ST_K6: r_plus <= K_1E7 + {1'b0, r_prod[57:34]};
            ST_K8: r_s    <= ({1'b0, r_plus} > w_minus) ? (r_plus - w_minus[24:0]) : '0;
            ST_M1: begin
                r_dlat <= (r_lat > r_home_lat) ? (r_lat - r_home_lat) : (r_home_lat - r_lat);
                r_dlon <= (r_lon > r_home_lon) ? (r_lon - r_home_lon) : (r_home_lon - r_lon);
            end
            ST_M3: r_num_n <= r_prod[44:0];
            ST_M4: r_num_e <= r_prod[44:0];
            // quotient estimates, each at most one below the true quotient
            ST_D1: r_qn <= r_prod[57:32];
            ST_D2: r_qe <= r_prod[57:32];
            ST_D3: begin
                if (w_rem_n >= {13'd0, K_1E6}) begin
                    r_qn <= r_qn + 26'd1;
                end
            end
            ST_S1: begin
                if (w_rem_e >= {13'd0, K_1E6}) begin
                    r_qe <= r_qe + 26'd1;
                end
            end
            ST_S2: r_sum <= {2'd0, r_prod[51:0]};
            ST_S3: r_sum <= r_sum + r_prod[53:0];
            ST_S4: begin
                r_sum <= r_sum + r_prod[53:0];
                r_res <= '0;
                r_bit <= SQRT_B0;
            end
            ST_SQRT: begin
                if (r_sum >= w_trial) begin
                    r_sum <= r_sum - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            default: ;
        endcase
        if (i_cmd.op == ST_FIN && w_out_free) begin
            if (r_opcode == OPC_MEASURE) begin
                r_out_dist <= w_dist;
                r_out_max  <= (w_dist > r_peak) ? w_dist : r_peak;
            end else begin
                r_out_dist <= '0;
                r_out_max  <= r_peak;
            end
        end
    end

    // control and home state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpd       <= MPD_RESET;
            r_home_lat  <= '0;
            r_home_lon  <= '0;
            r_axis      <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mpd <= i_cfg_wr_data;
            end
            if (i_cmd.op == ST_K11) begin
                r_home_lat <= r_lat;
                r_home_lon <= r_lon;
                r_axis     <= (r_prod[18:0] > AXIS_CAP) ? AXIS_CAP[16:0] : r_prod[16:0];
            end
            if (i_cmd.op == ST_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
                if (r_opcode == OPC_MEASURE && w_dist > r_peak) begin
                    r_peak <= w_dist;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_distance     = r_out_dist;
    assign o_max_distance = r_out_max;

    a_peak_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_peak >= $past(r_peak)))
        else $error("running maximum decreased");

    a_max_covers_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_max >= r_out_dist))
        else $error("reported maximum below reported distance");

endmodule

// ===== hdl/gps_home_distance_top.sv =====
// ----------------------------------------------------------------------------
// gps_home_distance_top
// Distance from a captured home position, computed from GPS fixes.
// ----------------------------------------------------------------------------
// Sequence: a capture item converts both coordinates and derives the home scale;
//   a measure item converts both coordinates, divides by one million and runs
//   the square root loop (27 steps), all on the single shared multiplier.
// Items: one item is taken at a time; the next item is taken once the
//   current result sits in the output register.
// Reset (i_rst_n low, synchronous) clears home, scale and peak to zero and
//   loads meters_per_degree with 111194.
// ----------------------------------------------------------------------------
module gps_home_distance_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: meters_per_degree
    input  logic        i_cfg_wr_en,
    input  logic [17:0] i_cfg_wr_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: lat_whole[13:0], lat_frac[27:14], lon_whole[42:28],
    //        lon_frac[56:43], baro_altitude[72:57], gps_altitude[88:73], zero fill
    input  logic [95:0] s_axis_tdata,
    // tuser: opcode[0], use_baro[1]
    input  logic [1:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: distance[24:0], max_distance[49:25], zero fill
    output logic [55:0] m_axis_tdata
);
    import ghd_pkg::*;

    t_cmd        w_cmd;
    t_stat       w_stat;
    logic [24:0] w_distance, w_max_distance;

    // Sequence the conversion, capture or measurement for one transfer.
    ghd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (w_stat),
        .o_ready    (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // Hold the item, the home state and the arithmetic; drive the result.
    ghd_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_opcode        (s_axis_tuser[0]),
        .i_lat_whole     (s_axis_tdata[13:0]),
        .i_lat_frac      (s_axis_tdata[27:14]),
        .i_lon_whole     (s_axis_tdata[42:28]),
        .i_lon_frac      (s_axis_tdata[56:43]),
        .i_baro_altitude (s_axis_tdata[72:57]),
        .i_gps_altitude  (s_axis_tdata[88:73]),
        .i_use_baro      (s_axis_tuser[1]),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_distance      (w_distance),
        .o_max_distance  (w_max_distance)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = {6'd0, w_max_distance, w_distance};

endmodule

// ===== test/gps_home_distance_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_home_distance_top_tb
// Self-checking bench for the GPS home distance block: fixes go in on the
// input stream, each result is compared with a predicted distance and peak.
// ----------------------------------------------------------------------------
module gps_home_distance_top_tb;
    import ghd_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;

    typedef struct {
        logic        opcode;
        logic [13:0] lat_whole;
        logic [13:0] lat_frac;
        logic [14:0] lon_whole;
        logic [13:0] lon_frac;
        logic [15:0] baro_alt;
        logic [15:0] gps_alt;
        logic        use_baro;
    } t_fix;

    typedef struct {
        logic [24:0] distance;
        logic [24:0] max_distance;
    } t_range;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [17:0] i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;

    // predictor state
    logic [63:0] mpd_q, home_lat_q, home_lon_q, scale_q, peak_q;
    t_range      range_q[$];
    int          errors;
    int          cycles;
    bit          idle_on;

    gps_home_distance_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Convert ddmm + fraction into micro-degrees, saturating at the cap.
    function automatic logic [63:0] micro_deg(logic [63:0] whole, logic [63:0] frac,
                                              logic [63:0] cap);
        logic [63:0] v;
        v = (whole / 100) * 1000000 + (((whole % 100) * 10000 + frac) * 5) / 3;
        return (v > cap) ? cap : v;
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] x);
        logic [63:0] res, bits;
        res = 0;
        bits = 64'd1 << 62;
        while (bits > x) bits = bits >> 2;
        while (bits != 0) begin
            if (x >= res + bits) begin
                x = x - (res + bits);
                res = (res >> 1) + bits;
            end else begin
                res = res >> 1;
            end
            bits = bits >> 2;
        end
        return res;
    endfunction

    // Advance the predictor by one fix and queue the result it gives.
    task automatic predict_range(t_fix f);
        logic [63:0] lat, lon, a, a2, a4, plus, minus, s, dlat, dlon, north, east, alt;
        logic [63:0] span;
        logic signed [15:0] sel;
        t_range r;
        lat = micro_deg(f.lat_whole, f.lat_frac, 64'd134217727);
        lon = micro_deg(f.lon_whole, f.lon_frac, 64'd268435455);
        span = 0;
        if (f.opcode == OPC_CAPTURE) begin
            a = lat / 10000;
            a2 = (a * a) / 10000;
            a4 = a2 * a2;
            plus = 10000000 + a4 / 25;
            minus = (a2 * 123370) / 81;
            s = (plus > minus) ? plus - minus : 0;
            home_lat_q = lat;
            home_lon_q = lon;
            scale_q = 139 * (s / 12500);
            if (scale_q > 64'h1FFFF) scale_q = 64'h1FFFF;
        end else begin
            dlat = (lat > home_lat_q) ? lat - home_lat_q : home_lat_q - lat;
            dlon = (lon > home_lon_q) ? lon - home_lon_q : home_lon_q - lon;
            north = mpd_q * dlat / 1000000;
            east = scale_q * dlon / 1000000;
            sel = f.use_baro ? f.baro_alt : f.gps_alt;
            alt = (sel < 0) ? 64'(-32'(sel)) : 64'(sel);
            span = root_floor(north * north + east * east + alt * alt);
            if (span > 64'd33554431) span = 64'd33554431;
            if (span > peak_q) peak_q = span;
        end
        r.distance = span[24:0];
        r.max_distance = peak_q[24:0];
        range_q.push_back(r);
    endtask

    // Send one fix; hold tvalid until the transfer completes.
    task automatic send_fix(t_fix f);
        while (idle_on && $urandom_range(99) < 21) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, f.gps_alt, f.baro_alt, f.lon_frac, f.lon_whole,
                          f.lat_frac, f.lat_whole};
        s_axis_tuser  <= {f.use_baro, f.opcode};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_range(f);
    endtask

    function automatic t_fix rand_fix(logic opc);
        t_fix f;
        f.opcode = opc;
        f.lat_whole = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(9059));
        f.lat_frac = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(9999));
        f.lon_whole = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(18059));
        f.lon_frac = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(9999));
        f.baro_alt = 16'($urandom);
        f.gps_alt = 16'($urandom);
        f.use_baro = 1'($urandom);
        return f;
    endfunction

    // Measure near home so distances stay small and realistic.
    function automatic t_fix near_fix(t_fix home);
        t_fix f;
        f = home;
        f.opcode = OPC_MEASURE;
        f.lat_frac = 14'($urandom_range(9999));
        f.lon_frac = 14'($urandom_range(9999));
        f.baro_alt = 16'($urandom_range(3000));
        f.gps_alt = 16'($urandom);
        f.use_baro = 1'($urandom);
        return f;
    endfunction

    // Drop tvalid and wait for all results before a write or the end.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (range_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_mpd(logic [17:0] v);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        mpd_q = 64'(v);
    endtask

    task automatic test_directed();
        t_fix f;
        f = '{OPC_MEASURE, 0, 0, 0, 0, 0, 0, 0};
        send_fix(f);
        f.baro_alt = 16'h8000; f.use_baro = 1'b1;
        send_fix(f);
        f = '{OPC_CAPTURE, 14'd4730, 14'd1234, 15'd830, 14'd5678, 0, 0, 0};
        send_fix(f);
        f.opcode = OPC_MEASURE; f.lat_whole = 14'd4731; f.gps_alt = 16'd500;
        send_fix(f);
        f = '{OPC_CAPTURE, 14'd0, 14'd0, 15'd0, 14'd0, 0, 0, 0};
        send_fix(f);
        f = '{OPC_MEASURE, 14'd9059, 14'd9999, 15'd18059, 14'd9999, 16'h7FFF, 16'h8000, 0};
        send_fix(f);
        // out-of-range fields: saturated coordinates, negative cosine term
        f = '{OPC_CAPTURE, 14'h3FFF, 14'h3FFF, 15'h7FFF, 14'h3FFF, 0, 0, 0};
        send_fix(f);
        f = '{OPC_MEASURE, 14'd0, 14'd0, 15'd0, 14'd0, 16'hFFFF, 16'h7FFF, 1};
        send_fix(f);
        f = '{OPC_CAPTURE, 14'd9000, 14'd0, 15'd18000, 14'd0, 0, 0, 0};
        send_fix(f);
        f = '{OPC_MEASURE, 14'd0, 14'd0, 15'd0, 14'd0, 16'h8000, 16'h8000, 1};
        send_fix(f);
        f = '{OPC_CAPTURE, 14'd0, 14'd0, 15'd0, 14'd0, 0, 0, 0};
        send_fix(f);
        f = '{OPC_MEASURE, 14'h3FFF, 14'h3FFF, 15'h7FFF, 14'h3FFF, 16'h8000, 0, 1};
        send_fix(f);
    endtask

    task automatic test_random(int count);
        t_fix home, f;
        home = rand_fix(OPC_CAPTURE);
        send_fix(home);
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
                0: begin
                    home = rand_fix(OPC_CAPTURE);
                    send_fix(home);
                end
                1, 2: begin
                    f = rand_fix(OPC_MEASURE);
                    send_fix(f);
                end
                default: begin
                    f = near_fix(home);
                    send_fix(f);
                end
            endcase
        end
    endtask

    // Check each result transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_range r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (range_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
                errors++;
            end else begin
                r = range_q.pop_front();
                if (m_axis_tdata[24:0] !== r.distance) begin
                    $display("%0t: distance expected %0d actual %0d", $time,
                             r.distance, m_axis_tdata[24:0]);
                    errors++;
                end
                if (m_axis_tdata[49:25] !== r.max_distance) begin
                    $display("%0t: max_distance expected %0d actual %0d", $time,
                             r.max_distance, m_axis_tdata[49:25]);
                    errors++;
                end
            end
        end
    end

    // Stall the result side at random while idling is enabled.
    always @(posedge i_clk) begin
        m_axis_tready <= !(idle_on && $urandom_range(99) < 21);
    end

    // Cycle watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        idle_on = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        mpd_q = 64'd111194;
        home_lat_q = 0; home_lon_q = 0; scale_q = 0; peak_q = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        idle_on = 1'b1;
        test_random(400);
        write_mpd(18'd1);
        test_directed();
        test_random(300);
        write_mpd(18'd200000);
        test_random(300);
        write_mpd(18'h3FFFF);
        test_random(200);
        write_mpd(18'd111194);
        // stretch with no idling
        idle_on = 1'b0;
        test_random(250);
        idle_on = 1'b1;
        write_mpd(18'($urandom_range(200000, 1)));
        test_random(250);
        drain();

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
